// ===== hw/rtl/abm4_pkg.sv =====
// Shared types, codes and arithmetic widths of the ABM4 predictor-corrector step.
package abm4_pkg;

  // Input kind codes (tuser)
  localparam logic [1:0] KIND_PRIME   = 2'd0;
  localparam logic [1:0] KIND_PREDICT = 2'd1;
  localparam logic [1:0] KIND_CORRECT = 2'd2;

  // Arithmetic widths: |S| <= 160 * 2^31 < 2^39
  localparam int SUM_W   = 40;
  localparam int MAG_W   = SUM_W - 1;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = MAG_W + FRAC_W;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 7;
  localparam int DIV_W   = DIV_BITS * DIV_STEPS;
  localparam int CNT_W   = $clog2(DIV_STEPS);
  localparam int RES_W   = 55;
  localparam int ELEM_W  = 4;
  localparam int WORD_W  = 32;
  localparam int MAX_DEPTH = 16;

  // Adams-Bashforth weights over (v, h0, h1, h2) after the shift
  localparam logic signed [SUM_W-1:0] AB_CV  = 40'sd55;
  localparam logic signed [SUM_W-1:0] AB_CH0 = -40'sd59;
  localparam logic signed [SUM_W-1:0] AB_CH1 = 40'sd37;
  localparam logic signed [SUM_W-1:0] AB_CH2 = -40'sd9;
  // Adams-Moulton weights over (v, h0, h1, h2)
  localparam logic signed [SUM_W-1:0] AM_CV  = 40'sd9;
  localparam logic signed [SUM_W-1:0] AM_CH0 = 40'sd19;
  localparam logic signed [SUM_W-1:0] AM_CH1 = -40'sd5;
  localparam logic signed [SUM_W-1:0] AM_CH2 = 40'sd1;

  // Half of 24, added before the divide for round half away from zero
  localparam logic [DIV_W-1:0] ROUND_HALF = 56'd12;
  localparam logic [1:0]       DIVISOR3   = 2'd3;

  localparam logic [WORD_W-1:0] STEP_RESET = 32'd655;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ABS,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ROUND,
    ST_DIV,
    ST_DONE
  } abm4_state_t;

  typedef struct packed {
    logic load;      // latch item, read memories
    logic update;    // write history/start, register weighted sum
    logic absval;    // split sum into sign and magnitude
    logic mul_hi;    // magnitude times integer part of dt
    logic mul_lo;    // magnitude times fraction part of dt
    logic round;     // combine products, add half, load divider
    logic div_step;  // one radix-256 step of the divide by three
    logic finish;    // add to start, saturate, load output word
  } abm4_cmd_t;

  typedef struct packed {
    logic item_ok;     // offered word has a valid kind and element
    logic is_prime;    // held item is a prime
  } abm4_stat_t;

endpackage

// ===== hw/rtl/abm4_ctrl.sv =====
// Sequencing state machine of the ABM4 step: handshakes, commands, divide count.
module abm4_ctrl
  import abm4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  abm4_stat_t stat,
  output abm4_cmd_t  cmd
);

  abm4_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (stat.item_ok) state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = stat.is_prime ? ST_IDLE : ST_ABS;
      end
      ST_ABS: begin
        cmd.absval = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output word is free or leaving this cycle
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/abm4_dp.sv =====
// Datapath of the ABM4 step: history and start memories, weighted sum, scale, round, saturate.
module abm4_dp
  import abm4_pkg::*;
#(
  parameter int NUM_ELEMENTS = 16
) (
  input  logic              clk,
  input  abm4_cmd_t         cmd,
  input  logic [WORD_W-1:0] step_size,
  input  logic [1:0]        in_kind,
  input  logic [ELEM_W-1:0] in_element,
  input  logic [WORD_W-1:0] in_velocity,
  input  logic [WORD_W-1:0] in_position,
  output abm4_stat_t        stat,
  output logic [ELEM_W-1:0] out_element,
  output logic [WORD_W-1:0] out_position
);

  localparam int DEPTH = (NUM_ELEMENTS < MAX_DEPTH) ? NUM_ELEMENTS : MAX_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W = 3 * WORD_W;

  // Only h0..h2 are ever read, so a row keeps three words: {h2, h1, h0}
  logic [ROW_W-1:0]  hist_mem [DEPTH];
  logic [WORD_W-1:0] start_mem [DEPTH];

  logic [1:0]        kind_r;
  logic [ELEM_W-1:0] elem_r;
  logic [WORD_W-1:0] vel_r, pos_r;
  logic [ROW_W-1:0]  row_r;
  logic [WORD_W-1:0] start_rd_r;

  logic signed [SUM_W-1:0] sum_r;
  logic                    neg_r;
  logic [MAG_W-1:0]        mag_r;
  logic [PROD_W-1:0]       hi_r, lo_r;
  logic [DIV_W-1:0]        div_r;
  logic [1:0]              rem_r;
  logic [ELEM_W-1:0]       out_elem_r;
  logic [WORD_W-1:0]       out_pos_r;

  logic [AW-1:0] idx_in, idx_r;
  assign idx_in = in_element[AW-1:0];
  assign idx_r  = elem_r[AW-1:0];

  // Item decode for the controller
  logic kind_ok, elem_ok;
  assign kind_ok = (in_kind == KIND_PRIME) || (in_kind == KIND_PREDICT)
                   || (in_kind == KIND_CORRECT);
  assign elem_ok = ({{(WORD_W-ELEM_W){1'b0}}, in_element} < WORD_W'(NUM_ELEMENTS));
  assign stat.item_ok  = kind_ok && elem_ok;
  assign stat.is_prime = (kind_r == KIND_PRIME);

  // Weighted sums over (v, h0, h1, h2); predict shifts first, so its taps line up
  logic signed [SUM_W-1:0] v_x, h0_x, h1_x, h2_x, sum_ab, sum_am;
  assign v_x  = {{(SUM_W-WORD_W){vel_r[WORD_W-1]}}, vel_r};
  assign h0_x = {{(SUM_W-WORD_W){row_r[WORD_W-1]}}, row_r[WORD_W-1:0]};
  assign h1_x = {{(SUM_W-WORD_W){row_r[2*WORD_W-1]}}, row_r[2*WORD_W-1:WORD_W]};
  assign h2_x = {{(SUM_W-WORD_W){row_r[3*WORD_W-1]}}, row_r[3*WORD_W-1:2*WORD_W]};
  assign sum_ab = v_x * AB_CV + h0_x * AB_CH0 + h1_x * AB_CH1 + h2_x * AB_CH2;
  assign sum_am = v_x * AM_CV + h0_x * AM_CH0 + h1_x * AM_CH1 + h2_x * AM_CH2;

  // Shared 39x16 multiplier
  logic [FRAC_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  assign mul_b = cmd.mul_hi ? step_size[WORD_W-1:FRAC_W] : step_size[FRAC_W-1:0];
  assign prod  = {{FRAC_W{1'b0}}, mag_r} * {{MAG_W{1'b0}}, mul_b};

  // q + 12, then the divide by 24 splits into a shift by 3 and a divide by 3
  logic [DIV_W-1:0] q_half;
  assign q_half = {1'b0, hi_r} + {{(DIV_W-PROD_W+FRAC_W){1'b0}}, lo_r[PROD_W-1:FRAC_W]}
                  + ROUND_HALF;

  // Eight restoring steps of divide by three, MSB first
  logic [DIV_BITS-1:0] qbits;
  logic [1:0]          rem_nxt;
  always_comb begin
    logic [2:0] x;
    logic [1:0] r;
    r = rem_r;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      x = {r, div_r[DIV_W-1-i]};
      if (x >= {1'b0, DIVISOR3}) begin
        qbits[DIV_BITS-1-i] = 1'b1;
        r = 2'(x - {1'b0, DIVISOR3});
      end else begin
        r = x[1:0];
      end
    end
    rem_nxt = r;
  end

  // Final add to the start value and saturation
  logic [WORD_W-1:0]       base;
  logic signed [RES_W-1:0] base_x, inc_x, res;
  logic [WORD_W-1:0]       res_sat;
  assign base   = (kind_r == KIND_PREDICT) ? pos_r : start_rd_r;
  assign base_x = {{(RES_W-WORD_W){base[WORD_W-1]}}, base};
  assign inc_x  = {{(RES_W-(DIV_W-3)){1'b0}}, div_r[DIV_W-4:0]};
  assign res    = neg_r ? (base_x - inc_x) : (base_x + inc_x);
  always_comb begin
    if (!res[RES_W-1] && (res[RES_W-2:WORD_W-1] != '0)) begin
      res_sat = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (res[RES_W-1] && (res[RES_W-2:WORD_W-1] != '1)) begin
      res_sat = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res_sat = res[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= in_kind;
      elem_r     <= in_element;
      vel_r      <= in_velocity;
      pos_r      <= in_position;
      row_r      <= hist_mem[idx_in];
      start_rd_r <= start_mem[idx_in];
    end
    if (cmd.update) begin
      if (kind_r != KIND_CORRECT) begin
        hist_mem[idx_r] <= {row_r[2*WORD_W-1:0], vel_r};
      end
      if (kind_r == KIND_PREDICT) begin
        start_mem[idx_r] <= pos_r;
      end
      sum_r <= (kind_r == KIND_PREDICT) ? sum_ab : sum_am;
    end
    if (cmd.absval) begin
      neg_r <= sum_r[SUM_W-1];
      mag_r <= sum_r[SUM_W-1] ? MAG_W'(-sum_r) : sum_r[MAG_W-1:0];
    end
    if (cmd.mul_hi) hi_r <= prod;
    if (cmd.mul_lo) lo_r <= prod;
    if (cmd.round) begin
      div_r <= {3'b000, q_half[DIV_W-1:3]};
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      div_r <= {div_r[DIV_W-DIV_BITS-1:0], qbits};
      rem_r <= rem_nxt;
    end
    if (cmd.finish) begin
      out_elem_r <= elem_r;
      out_pos_r  <= res_sat;
    end
  end

  assign out_element  = out_elem_r;
  assign out_position = out_pos_r;

endmodule

// ===== hw/rtl/abm4_predictor_corrector_step.sv =====
// Top level of the fourth-order Adams-Bashforth-Moulton predictor-corrector step.
//
// One word per state element: tuser carries the kind (prime, predict, correct),
// tdata the element index, its derivative and, for predict, its start value, all
// signed Q16.16. Prime shifts the element's derivative history; predict shifts it,
// records the start value and returns start + dt*(55h0-59h1+37h2-9h3)/24; correct
// returns start + dt*(9v+19h0-5h1+h2)/24 and leaves the state alone. The increment
// is rounded to nearest with halves away from zero and the sum saturates to 32 bits.
// Words with kind 3 or an element at or above NUM_ELEMENTS are taken and dropped.
// One word is worked on at a time. A prime goes through the read and the history update
// only and a dropped word through the read alone; a predict or correct goes through the
// sequence read/update, magnitude, two 39x16 partial products through one shared
// multiplier, rounding, and seven radix-256 steps of the divide by three, then waits
// while the previous result still waits on out_tready. A finished result sits in the
// output register while the next word is already accepted.
// step_size (dt, unsigned Q16.16, reset 655) lies at APB byte address 0; write it
// only while the block is idle. History and start values read before first being
// written are undefined.
module abm4_predictor_corrector_step
  import abm4_pkg::*;
#(
  parameter int NUM_ELEMENTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // element[3:0], velocity[35:4], position[67:36], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // element_out[3:0], new_position[35:4], zero pad
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Register file: step_size only, decoded on the word address bit
  logic [WORD_W-1:0] step_r, step_nxt;
  logic              step_sel;

  assign step_sel   = (cfg_paddr[2] == 1'b0);
  assign cfg_pready = 1'b1;

  always_comb begin
    step_nxt = step_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && step_sel) begin
      step_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign cfg_prdata = step_sel ? step_r : '0;

  // Controller and datapath
  abm4_cmd_t         cmd;
  abm4_stat_t        stat;
  logic [ELEM_W-1:0] res_elem;
  logic [WORD_W-1:0] res_pos;

  abm4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  abm4_dp #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .step_size    (step_r),
    .in_kind      (in_tuser),
    .in_element   (in_tdata[3:0]),
    .in_velocity  (in_tdata[35:4]),
    .in_position  (in_tdata[67:36]),
    .stat         (stat),
    .out_element  (res_elem),
    .out_position (res_pos)
  );

  // Pad the result word to whole bytes
  assign out_tdata = {4'b0000, res_pos, res_elem};

endmodule

// ===== hw/rtl/abm4_chk.sv =====
// Port-level checker for the ABM4 step, bound to the top level.
module abm4_chk
  import abm4_pkg::*;
#(
  parameter int NUM_ELEMENTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);

  logic work_item;
  assign work_item = in_tvalid && in_tready
                     && ((in_tuser == KIND_PRIME) || (in_tuser == KIND_PREDICT)
                         || (in_tuser == KIND_CORRECT))
                     && ({28'd0, in_tdata[3:0]} < 32'(NUM_ELEMENTS));

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // a word that does work blocks the input on the next cycle
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    work_item |=> !in_tready)
    else $error("input taken while a word is being processed");

  // a new result is never loaded in a cycle that also accepted a word
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared right after an acceptance");

endmodule

bind abm4_predictor_corrector_step abm4_chk #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_chk (.*);

// ===== sim/tb_abm4_predictor_corrector_step.sv =====
// Self-checking testbench for the ABM4 predictor-corrector step: stream and APB stimulus.
`timescale 1ns / 100ps

module tb_abm4_predictor_corrector_step
  import abm4_pkg::*;
;

  localparam int NUM_ELEMENTS = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_STEP_SIZE = 3'd0;
  localparam logic [31:0] STEP_SIZE_AT_RESET = 32'd655;
  // Settling time after the last result, before the register is touched.
  localparam int IDLE_SETTLE = 24;
  localparam int WORDS_PER_PHASE = 180;
  localparam int MAX_REPORTS = 10;

  // Adams-Bashforth weights over the shifted history h0..h3
  localparam longint AB_W0 = 55;
  localparam longint AB_W1 = -59;
  localparam longint AB_W2 = 37;
  localparam longint AB_W3 = -9;
  // Adams-Moulton weights over the fresh derivative and h0..h2
  localparam longint AM_WV = 9;
  localparam longint AM_W0 = 19;
  localparam longint AM_W1 = -5;
  localparam longint AM_W2 = 1;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [3:0]  element;
    logic [31:0] position;
  } position_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // element[3:0], velocity[35:4], position[67:36], zero pad
  logic [1:0]  in_tuser = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // element_out[3:0], new_position[35:4], zero pad
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the block: step size, derivative history and start values per element.
  logic [31:0]        step_size_now = STEP_SIZE_AT_RESET;
  logic signed [31:0] history [NUM_ELEMENTS][4];
  logic signed [31:0] start_of_step [NUM_ELEMENTS];
  // Track which entries hold data, so no word ever reads an unwritten one.
  int                 hist_fill [NUM_ELEMENTS];
  bit                 start_known [NUM_ELEMENTS];

  position_word_t pending_positions [$];
  int             mismatch_count = 0;
  bit             steady_flow = 1'b0;   // high: neither side idles

  always #10 clk = ~clk;

  abm4_predictor_corrector_step #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Count a mismatch; print only the first few in full.
  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // start + round(S*dt / (24*2^16)), halves away from zero, saturated to 32 bits.
  function automatic logic [31:0] advanced_position(input logic signed [31:0] start,
                                                    input longint wsum,
                                                    input logic [31:0] dt);
    logic [63:0] mag;
    logic [63:0] part_int;
    logic [63:0] part_frac;
    logic [63:0] incr;
    longint      sum;
    mag = (wsum < 0) ? 64'(-wsum) : 64'(wsum);
    part_int  = mag * {48'd0, dt[31:16]};
    part_frac = mag * {48'd0, dt[15:0]};
    incr = (part_int + (part_frac >> 16) + 64'd12) / 64'd24;
    sum = (wsum < 0) ? longint'(start) - longint'(incr) : longint'(start) + longint'(incr);
    if (sum > SAT_HI) sum = SAT_HI;
    if (sum < SAT_LO) sum = SAT_LO;
    return sum[31:0];
  endfunction

  // Apply one accepted word to the shadow state; queue the new position it yields.
  task automatic track_word(input logic [1:0] kind, input logic [3:0] elem,
                            input logic signed [31:0] vel, input logic signed [31:0] pos);
    longint         wsum;
    position_word_t want;
    if (kind == KIND_PRIME || kind == KIND_PREDICT) begin
      history[elem][3] = history[elem][2];
      history[elem][2] = history[elem][1];
      history[elem][1] = history[elem][0];
      history[elem][0] = vel;
      if (hist_fill[elem] < 4) hist_fill[elem]++;
    end
    if (kind == KIND_PREDICT) begin
      start_of_step[elem] = pos;
      start_known[elem] = 1'b1;
      wsum = AB_W0 * longint'(history[elem][0]) + AB_W1 * longint'(history[elem][1])
           + AB_W2 * longint'(history[elem][2]) + AB_W3 * longint'(history[elem][3]);
    end else if (kind == KIND_CORRECT) begin
      wsum = AM_WV * longint'(vel) + AM_W0 * longint'(history[elem][0])
           + AM_W1 * longint'(history[elem][1]) + AM_W2 * longint'(history[elem][2]);
    end
    if (kind == KIND_PREDICT || kind == KIND_CORRECT) begin
      want.element = elem;
      want.position = advanced_position(start_of_step[elem], wsum, step_size_now);
      pending_positions.push_back(want);
    end
  endtask

  // Offer one word, hold it until taken, then update the shadow state.
  task automatic send_word(input logic [1:0] kind, input logic [3:0] elem,
                           input logic [31:0] vel, input logic [31:0] pos);
    if (!steady_flow) begin
      while ($urandom_range(99) < 27) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, pos, vel, elem};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_word(kind, elem, vel, pos);
  endtask

  // Drop valid and let every queued result come out, then give the block time to settle.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic read_step_size(output logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_STEP_SIZE;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    value = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write dt while the block is idle, then read it back.
  task automatic set_step_size(input logic [31:0] value);
    logic [31:0] readback;
    wait_until_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_STEP_SIZE;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    step_size_now = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    read_step_size(readback);
    if (readback !== value) note_mismatch("step_size readback", value, readback);
  endtask

  // Extremes now and then, else small or full-range values so not all results saturate.
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if (sel < 55) return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    return $urandom;
  endfunction

  // Result side: stall at random, compare each taken word with the oldest expectation.
  always @(posedge clk) begin : result_check
    position_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_positions.size() == 0) begin
        note_mismatch("result with none outstanding", 32'd0, out_tdata[35:4]);
      end else begin
        want = pending_positions.pop_front();
        if (out_tdata[3:0] !== want.element)
          note_mismatch("element_out", 32'(want.element), 32'(out_tdata[3:0]));
        if (out_tdata[35:4] !== want.position)
          note_mismatch("new_position", want.position, out_tdata[35:4]);
      end
    end
    out_tready <= steady_flow || ($urandom_range(99) >= 27);
  end

  // Reset value of dt, then extremes of every field on the first and last element,
  // every kind, and words of the unused kind that must be dropped.
  task automatic test_field_extremes();
    logic [31:0] dt_seen;
    read_step_size(dt_seen);
    if (dt_seen !== STEP_SIZE_AT_RESET)
      note_mismatch("step_size at reset", STEP_SIZE_AT_RESET, dt_seen);
    send_word(KIND_UNUSED, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(KIND_PRIME, 4'd0, 32'h8000_0000, 32'h0);
    send_word(KIND_PRIME, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_PRIME, 4'd0, 32'hFFFF_FFFF, 32'h0);
    send_word(KIND_PREDICT, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(KIND_CORRECT, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(KIND_PRIME, 4'd15, 32'h7FFF_FFFF, 32'h0);
    send_word(KIND_PRIME, 4'd15, 32'h8000_0000, 32'h0);
    send_word(KIND_PRIME, 4'd15, 32'h0001_0000, 32'h0);
    send_word(KIND_PREDICT, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_CORRECT, 4'd15, 32'hFFFF_FFFF, 32'h0);
  endtask

  // dt = 1.0 and a lone derivative of 12 puts the increment at exactly 27.5: ties go
  // away from zero in both directions.
  task automatic test_rounding_ties();
    set_step_size(32'h0001_0000);
    repeat (3) send_word(KIND_PRIME, 4'd5, 32'h0, 32'h0);
    repeat (3) send_word(KIND_PRIME, 4'd6, 32'h0, 32'h0);
    send_word(KIND_PREDICT, 4'd5, 32'd12, 32'h0);
    send_word(KIND_PREDICT, 4'd6, -32'sd12, 32'h7FFF_FFFF);
    send_word(KIND_CORRECT, 4'd5, 32'd4, 32'h0);
    send_word(KIND_CORRECT, 4'd6, -32'sd4, 32'h0);
  endtask

  // Largest dt drives both rails; dt = 0 must hand back the start value untouched.
  task automatic test_saturation();
    set_step_size(32'hFFFF_FFFF);
    repeat (3) send_word(KIND_PRIME, 4'd1, 32'h7FFF_FFFF, 32'h0);
    repeat (3) send_word(KIND_PRIME, 4'd2, 32'h8000_0000, 32'h0);
    send_word(KIND_PREDICT, 4'd1, 32'h7FFF_FFFF, 32'h7F00_0000);
    send_word(KIND_PREDICT, 4'd2, 32'h8000_0000, 32'h8000_0100);
    send_word(KIND_CORRECT, 4'd1, 32'h8000_0000, 32'h0);
    set_step_size(32'h0000_0000);
    send_word(KIND_CORRECT, 4'd1, 32'h7FFF_FFFF, 32'h0);
    send_word(KIND_PREDICT, 4'd2, 32'h1234_5678, 32'hDEAD_BEEF);
  endtask

  // Random integration steps over several dt settings. Predict and correct are only
  // issued once the element's history (and start value) are set; a correct falls back
  // to a predict, a predict to a prime. Dropped words do not count toward the phase.
  task automatic test_random_integration();
    logic [31:0] dt_choice [6];
    int          sent;
    int unsigned roll;
    logic [3:0]  elem;
    logic [1:0]  kind;
    dt_choice[0] = $urandom_range(1, 32'h0002_0000);
    dt_choice[1] = 32'h0001_0000;
    dt_choice[2] = $urandom;
    dt_choice[3] = $urandom_range(0, 32'h0000_FFFF);
    dt_choice[4] = 32'hFFFF_FFFF;
    dt_choice[5] = 32'h0000_0001;
    for (int phase = 0; phase < 6; phase++) begin
      set_step_size(dt_choice[phase]);
      steady_flow = (phase == 2);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        elem = 4'($urandom_range(NUM_ELEMENTS - 1));
        roll = $urandom_range(99);
        if (roll < 5)       kind = KIND_UNUSED;
        else if (roll < 30) kind = KIND_PRIME;
        else if (roll < 65) kind = KIND_PREDICT;
        else                kind = KIND_CORRECT;
        // Hold back words that would read history or start values never written.
        if (kind == KIND_CORRECT && !(hist_fill[elem] >= 3 && start_known[elem]))
          kind = KIND_PREDICT;
        if (kind == KIND_PREDICT && hist_fill[elem] < 3)
          kind = KIND_PRIME;
        send_word(kind, elem, pick_value(), pick_value());
        if (kind != KIND_UNUSED) sent++;
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    for (int e = 0; e < NUM_ELEMENTS; e++) begin
      hist_fill[e] = 0;
      start_known[e] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_rounding_ties();
    test_saturation();
    test_random_integration();
    wait_until_idle();
    if (mismatch_count == 0 && pending_positions.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
